// File: src/lrusa_pkg.sv
// lrusa_pkg: shared types and constants for the lru slot allocator
package lrusa_pkg;

	localparam int KEY_W  = 64;
	localparam int SLOT_W = 6;
	localparam int POS_W  = 4;

	typedef enum logic [1:0] {
		ST_EMPTY,
		ST_TRANSFER,
		ST_OCCUPIED
	} slot_state_t;

	typedef enum logic [1:0] {
		MODE_REQUEST,
		MODE_COMPLETE,
		MODE_CANCEL,
		MODE_EVICT
	} mode_t;

	typedef enum logic [2:0] {
		OC_AVAILABLE,
		OC_TRANSFERRING,
		OC_START,
		OC_OVERFLOW,
		OC_DONE,
		OC_BAD_STATE
	} outcome_t;

	typedef enum logic [1:0] {
		OP_NONE,
		OP_NEWEST,
		OP_OLDEST,
		OP_STATE
	} cell_op_t;

	typedef struct packed {
		cell_op_t    op;
		logic        by_key;
		slot_state_t new_state;
	} cell_cmd_t;

	typedef struct packed {
		logic [1:0]       mode;
		logic [KEY_W-1:0] key;
		logic [SLOT_W-1:0] slot;
		logic             batch_last;
	} in_item_t;

	typedef struct packed {
		logic [POS_W-1:0]  position;
		outcome_t          outcome;
		logic [SLOT_W-1:0] slot_index;
		logic [KEY_W-1:0]  previous_key;
		logic              last;
	} out_item_t;

endpackage

// File: src/lrusa_ram.sv
// lrusa_ram: generic single write port ram with registered read
module lrusa_ram #(
	parameter int W = 64,
	parameter int D = 16
) (
	input  logic                              clk,
	input  logic                              we,
	input  logic [(D > 1 ? $clog2(D) : 1)-1:0] waddr,
	input  logic [W-1:0]                      wdata,
	input  logic [(D > 1 ? $clog2(D) : 1)-1:0] raddr,
	output logic [W-1:0]                      rdata
);
	logic [W-1:0] mem_q [D];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

// File: src/lrusa_cell.sv
// lrusa_cell: one lru position holding a slot id, its state and its key
module lrusa_cell import lrusa_pkg::*; #(
	parameter int SB        = 6,
	parameter int KW        = 64,
	parameter int INIT_SLOT = 0
) (
	input  logic        clk,
	input  logic        arst_n,
	input  cell_cmd_t   cmd,
	input  logic [KW-1:0] cmp_key,
	input  logic [SB-1:0] cmp_slot,
	input  logic [SB-1:0] up_slot,
	input  slot_state_t up_state,
	input  logic [KW-1:0] up_key,
	input  logic [SB-1:0] dn_slot,
	input  slot_state_t dn_state,
	input  logic [KW-1:0] dn_key,
	input  logic        below_in,
	input  logic        above_in,
	output logic [SB-1:0] slot_q,
	output slot_state_t state_q,
	output logic [KW-1:0] key_q,
	output logic        sel,
	output logic        below_out,
	output logic        above_out
);
	always_comb begin
		if (cmd.by_key) begin
			sel = (state_q != ST_EMPTY) && (key_q == cmp_key);
		end else begin
			sel = (slot_q == cmp_slot);
		end
	end

	assign below_out = below_in | sel;
	assign above_out = above_in | sel;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_q  <= SB'(INIT_SLOT);
			state_q <= ST_EMPTY;
			key_q   <= '0;
		end else begin
			case (cmd.op)
				OP_NEWEST: begin
					if (below_out) begin
						slot_q  <= up_slot;
						state_q <= up_state;
						key_q   <= up_key;
					end
				end
				OP_OLDEST: begin
					if (above_out) begin
						slot_q  <= dn_slot;
						state_q <= dn_state;
						key_q   <= dn_key;
					end
				end
				OP_STATE: begin
					if (sel) begin
						state_q <= cmd.new_state;
					end
				end
				default: begin
				end
			endcase
		end
	end
endmodule

// File: src/lru_slot_allocator_with_transfers.sv
// lru_slot_allocator_with_transfers: lru tag store with batched requests and slot events
//
//  channel  | ports                                   | accepted when
//  ---------+-----------------------------------------+--------------------------------
//  item     | start, busy, item                       | start && !busy
//  result   | result_strobe, result                   | every cycle result_strobe is high
//  config   | psel, penable, pwrite, paddr, pwdata... | psel && penable && pwrite
//
//  a stored request that does not close a batch leaves the block idle
//  an event goes through lookup, update and result
//  a batch goes through a prime step, a hit pass, a miss pass and a result pass
//  the passes are paced by the lru cell chain, updated once per lookup, and the single write port key ram
//  reset puts slot 0 at the oldest place and every slot empty; no clearing pass
//  results cannot be stalled; each is on the port for one cycle
module lru_slot_allocator_with_transfers import lrusa_pkg::*; #(
	parameter int SLOTS    = 64,
	parameter int BATCH    = 16,
	parameter int KEY_BITS = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  in_item_t    item,
	output logic        result_strobe,
	output out_item_t   result,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [63:0] pwdata,
	output logic [63:0] prdata,
	output logic        pready
);
	localparam int SB = $clog2(SLOTS);
	localparam int SW = (SB > SLOT_W) ? SB : SLOT_W;
	localparam int CW = $clog2(BATCH + 1);
	localparam int AW = (BATCH > 1) ? $clog2(BATCH) : 1;
	localparam int LW = $clog2(SLOTS + BATCH + 1);

	typedef enum logic [3:0] {
		S_IDLE, S_EV_LOOK, S_EV_ACT, S_PRIME, S_H_LOOK, S_H_ACT, S_M_LOOK, S_M_ACT, S_OUT
	} seq_state_t;

	seq_state_t state_q;
	logic [CW-1:0] cnt_q, n_q, c_q, hits_q, m_q, c_d;
	mode_t mode_q;
	logic [SLOT_W-1:0] slot_q;
	logic [KEY_BITS-1:0] key_q, prev_q, dummy_q;
	logic f_found_q;
	slot_state_t f_state_q;
	logic [SB-1:0] f_slot_q;
	logic [KEY_BITS-1:0] f_key_q;
	logic r_hit_q [BATCH];
	outcome_t r_oc_q [BATCH];
	logic [SB-1:0] r_idx_q [BATCH];
	logic [KEY_BITS-1:0] r_prev_q [BATCH];
	out_item_t result_q;
	logic result_strobe_q;

	logic [SB-1:0] c_slot [SLOTS];
	slot_state_t c_state [SLOTS];
	logic [KEY_BITS-1:0] c_key [SLOTS];
	logic [SLOTS-1:0] sel;
	logic [SLOTS:0] below, above;

	cell_cmd_t cmd;
	logic [KEY_BITS-1:0] cmp_key, ins_key, m_key, rd_data;
	logic [SB-1:0] cmp_slot, ins_slot, m_slot;
	slot_state_t ins_state, m_state;
	logic m_found;
	logic [SLOTS-1:0] hit_vec;
	logic [SB-1:0] h_slot;

	logic accept, req_store, last_c, ovf_cond, ev_ok, slot_ok;
	logic [SW-1:0] slot_ext;
	logic [CW-1:0] n_new, c_inc;
	logic [AW-1:0] ci;
	slot_state_t need;

	assign accept   = start && !busy;
	assign busy     = (state_q != S_IDLE);
	assign req_store = accept && (item.mode == MODE_REQUEST) && (cnt_q < CW'(BATCH));
	assign n_new    = cnt_q + CW'(cnt_q < CW'(BATCH));
	assign c_inc    = c_q + CW'(1);
	assign last_c   = (c_inc == n_q);
	assign ci       = c_q[AW-1:0];
	assign slot_ext = SW'(slot_q);
	assign slot_ok  = ((SW+1)'(slot_ext) < (SW+1)'(SLOTS));
	assign need     = (mode_q == MODE_EVICT) ? ST_OCCUPIED : ST_TRANSFER;
	assign ev_ok    = f_found_q && slot_ok && (f_state_q == need);
	assign ovf_cond = (LW'(m_q) + LW'(hits_q) >= LW'(SLOTS)) || (c_state[0] == ST_TRANSFER);

	assign pready        = 1'b1;
	assign prdata        = KEY_W'(dummy_q);
	assign result        = result_q;
	assign result_strobe = result_strobe_q;

	lrusa_ram #(.W(KEY_BITS), .D(BATCH)) u_keys (
		.clk  (clk),
		.we   (req_store),
		.waddr(cnt_q[AW-1:0]),
		.wdata(KEY_BITS'(item.key)),
		.raddr(c_d[AW-1:0]),
		.rdata(rd_data)
	);

	always_comb begin
		m_found = |sel;
		m_slot  = '0;
		m_state = ST_EMPTY;
		m_key   = '0;
		for (int i = 0; i < SLOTS; i++) begin
			m_slot  = m_slot | (sel[i] ? c_slot[i] : '0);
			m_state = slot_state_t'(m_state | (sel[i] ? c_state[i] : ST_EMPTY));
			m_key   = m_key | (sel[i] ? c_key[i] : '0);
		end
	end

	// lowest slot id among the cells that match the key
	always_comb begin
		hit_vec = '0;
		for (int i = 0; i < SLOTS; i++) begin
			if (sel[i]) begin
				hit_vec[c_slot[i]] = 1'b1;
			end
		end
		h_slot = '0;
		for (int i = SLOTS - 1; i >= 0; i--) begin
			if (hit_vec[i]) begin
				h_slot = SB'(i);
			end
		end
	end

	always_comb begin
		c_d = c_q;
		case (state_q)
			S_IDLE: c_d = '0;
			S_H_ACT, S_M_ACT: c_d = last_c ? '0 : c_inc;
			S_M_LOOK: begin
				if (r_hit_q[ci] || ovf_cond) begin
					c_d = last_c ? '0 : c_inc;
				end
			end
			S_OUT: c_d = c_inc;
			default: c_d = c_q;
		endcase
	end

	always_comb begin
		cmd       = '{op: OP_NONE, by_key: 1'b0, new_state: ST_OCCUPIED};
		cmp_key   = key_q;
		cmp_slot  = slot_ext[SB-1:0];
		ins_slot  = f_slot_q;
		ins_state = f_state_q;
		ins_key   = f_key_q;
		case (state_q)
			S_EV_ACT: begin
				if (ev_ok) begin
					if (mode_q == MODE_COMPLETE) begin
						cmd.op = OP_STATE;
					end else begin
						cmd.op    = OP_OLDEST;
						ins_state = ST_EMPTY;
					end
				end
			end
			S_H_LOOK: begin
				cmd.by_key = 1'b1;
				cmp_key    = rd_data;
			end
			S_H_ACT: begin
				cmp_slot  = f_slot_q;
				ins_state = m_state;
				ins_key   = m_key;
				if (f_found_q) begin
					cmd.op = OP_NEWEST;
				end
			end
			S_M_ACT: begin
				cmd.op    = OP_NEWEST;
				cmp_slot  = c_slot[0];
				ins_slot  = c_slot[0];
				ins_state = ST_TRANSFER;
				ins_key   = key_q;
			end
			default: begin
			end
		endcase
	end

	assign below[0]     = 1'b0;
	assign above[SLOTS] = 1'b0;

	for (genvar i = 0; i < SLOTS; i++) begin : g_cell
		logic [SB-1:0] up_slot, dn_slot;
		slot_state_t up_state, dn_state;
		logic [KEY_BITS-1:0] up_key, dn_key;

		if (i == SLOTS - 1) begin : g_top
			assign up_slot  = ins_slot;
			assign up_state = ins_state;
			assign up_key   = ins_key;
		end else begin : g_mid
			assign up_slot  = c_slot[i+1];
			assign up_state = c_state[i+1];
			assign up_key   = c_key[i+1];
		end
		if (i == 0) begin : g_bot
			assign dn_slot  = ins_slot;
			assign dn_state = ins_state;
			assign dn_key   = ins_key;
		end else begin : g_low
			assign dn_slot  = c_slot[i-1];
			assign dn_state = c_state[i-1];
			assign dn_key   = c_key[i-1];
		end

		lrusa_cell #(.SB(SB), .KW(KEY_BITS), .INIT_SLOT(i)) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.cmd      (cmd),
			.cmp_key  (cmp_key),
			.cmp_slot (cmp_slot),
			.up_slot  (up_slot),
			.up_state (up_state),
			.up_key   (up_key),
			.dn_slot  (dn_slot),
			.dn_state (dn_state),
			.dn_key   (dn_key),
			.below_in (below[i]),
			.above_in (above[i+1]),
			.slot_q   (c_slot[i]),
			.state_q  (c_state[i]),
			.key_q    (c_key[i]),
			.sel      (sel[i]),
			.below_out(below[i+1]),
			.above_out(above[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dummy_q <= '0;
		end else if (psel && penable && pwrite && pready && (paddr == '0)) begin
			dummy_q <= KEY_BITS'(pwdata);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= S_IDLE;
			cnt_q           <= '0;
			n_q             <= '0;
			c_q             <= '0;
			hits_q          <= '0;
			m_q             <= '0;
			result_strobe_q <= 1'b0;
		end else begin
			result_strobe_q <= 1'b0;
			c_q             <= c_d;
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						mode_q <= mode_t'(item.mode);
						slot_q <= item.slot;
						if (item.mode == MODE_REQUEST) begin
							cnt_q <= n_new;
							if (item.batch_last && (n_new != '0)) begin
								n_q     <= n_new;
								hits_q  <= '0;
								m_q     <= '0;
								state_q <= S_PRIME;
							end
						end else begin
							state_q <= S_EV_LOOK;
						end
					end
				end
				S_EV_LOOK: begin
					f_found_q <= m_found;
					f_state_q <= m_state;
					f_slot_q  <= m_slot;
					f_key_q   <= m_key;
					state_q   <= S_EV_ACT;
				end
				S_EV_ACT: begin
					result_q <= '{position: '0,
						outcome: ev_ok ? OC_DONE : OC_BAD_STATE,
						slot_index: slot_q, previous_key: KEY_W'(dummy_q), last: 1'b1};
					result_strobe_q <= 1'b1;
					state_q         <= S_IDLE;
				end
				S_PRIME: state_q <= S_H_LOOK;
				S_H_LOOK: begin
					f_found_q <= m_found;
					f_state_q <= m_state;
					f_slot_q  <= h_slot;
					f_key_q   <= m_key;
					key_q     <= rd_data;
					state_q   <= S_H_ACT;
				end
				S_H_ACT: begin
					r_hit_q[ci]  <= f_found_q;
					r_oc_q[ci]   <= (m_state == ST_OCCUPIED) ? OC_AVAILABLE : OC_TRANSFERRING;
					r_idx_q[ci]  <= f_slot_q;
					r_prev_q[ci] <= key_q;
					if (f_found_q) begin
						hits_q <= hits_q + CW'(1);
					end
					state_q <= last_c ? S_M_LOOK : S_H_LOOK;
				end
				S_M_LOOK: begin
					if (r_hit_q[ci]) begin
						if (last_c) begin
							state_q <= S_OUT;
						end
					end else if (ovf_cond) begin
						r_oc_q[ci]   <= OC_OVERFLOW;
						r_idx_q[ci]  <= '0;
						r_prev_q[ci] <= dummy_q;
						if (last_c) begin
							state_q <= S_OUT;
						end
					end else begin
						prev_q  <= (c_state[0] != ST_EMPTY) ? c_key[0] : dummy_q;
						key_q   <= rd_data;
						state_q <= S_M_ACT;
					end
				end
				S_M_ACT: begin
					r_oc_q[ci]   <= OC_START;
					r_idx_q[ci]  <= c_slot[0];
					r_prev_q[ci] <= prev_q;
					m_q          <= m_q + CW'(1);
					state_q      <= last_c ? S_OUT : S_M_LOOK;
				end
				S_OUT: begin
					result_q <= '{position: POS_W'(c_q), outcome: r_oc_q[ci],
						slot_index: SLOT_W'(r_idx_q[ci]), previous_key: KEY_W'(r_prev_q[ci]),
						last: last_c};
					result_strobe_q <= 1'b1;
					if (last_c) begin
						cnt_q   <= '0;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	a_slot_unique: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_EV_LOOK || state_q == S_EV_ACT) |-> $onehot0(sel))
		else $error("several cells hold the same slot");
	a_key_unique: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_H_ACT) |-> $onehot0(sel))
		else $error("hit slot held by several cells");
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(BATCH))
		else $error("batch count beyond batch size");
	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(result_strobe_q && result_q.last) |-> !busy)
		else $error("final result while still busy");
endmodule
